// File: hdl/bqlp_pkg.sv
package bqlp_pkg;

   localparam int SAMPLE_WIDTH_DEF    = 32;
   localparam int COEFF_FRAC_BITS_DEF = 20;

   localparam int GAIN_W    = 21;
   localparam int COEF_W    = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TWO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_ONE = 2'd2;

   localparam logic CMD_FILTER  = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   // multiplier: 33-bit signed coefficient times one 32-bit operand chunk
   localparam int CHUNK_W   = 32;
   localparam int MUL_A_W   = COEF_W + 1;
   localparam int MUL_B_W   = CHUNK_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;

   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] STEP_FIRST  = 4'd0;
   localparam logic [PC_W-1:0] STEP_FINISH = 4'd8;

   localparam logic [1:0] MUL_NONE    = 2'd0;
   localparam logic [1:0] MUL_ALWAYS  = 2'd1;
   localparam logic [1:0] MUL_IF_MORE = 2'd2;

   localparam logic [1:0] COEF_FB_TWO = 2'd0;
   localparam logic [1:0] COEF_FB_ONE = 2'd1;
   localparam logic [1:0] COEF_GAIN   = 2'd2;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_LOAD_Y1 = 2'd1;
   localparam logic [1:0] ACT_LOAD_IN = 2'd2;
   localparam logic [1:0] ACT_FINISH  = 2'd3;

   localparam logic JMP_NEXT = 1'b0;
   localparam logic JMP_LOOP = 1'b1;

   typedef struct packed {
      logic [1:0] mul;
      logic [1:0] coef_sel;
      logic       acc_en;
      logic [1:0] act;
      logic       jump;
   } uop_type;

   typedef struct packed {
      logic       mul_en;
      logic [1:0] coef_sel;
      logic       acc_en;
      logic [1:0] act;
   } dp_ctrl_type;

   function automatic uop_type ucode_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{mul: MUL_NONE, coef_sel: COEF_FB_TWO, acc_en: 1'b0, act: ACT_NONE, jump: JMP_NEXT};
      unique case (pc)
         4'd0: begin
            u.mul = MUL_ALWAYS;   u.coef_sel = COEF_FB_TWO;
         end
         4'd1: begin
            u.mul = MUL_IF_MORE;  u.coef_sel = COEF_FB_TWO;
            u.acc_en = 1'b1;      u.jump = JMP_LOOP;
         end
         4'd2: begin
            u.act = ACT_LOAD_Y1;
         end
         4'd3: begin
            u.mul = MUL_ALWAYS;   u.coef_sel = COEF_FB_ONE;
         end
         4'd4: begin
            u.mul = MUL_IF_MORE;  u.coef_sel = COEF_FB_ONE;
            u.acc_en = 1'b1;      u.jump = JMP_LOOP;
         end
         4'd5: begin
            u.act = ACT_LOAD_IN;
         end
         4'd6: begin
            u.mul = MUL_ALWAYS;   u.coef_sel = COEF_GAIN;
         end
         4'd7: begin
            u.mul = MUL_IF_MORE;  u.coef_sel = COEF_GAIN;
            u.acc_en = 1'b1;      u.jump = JMP_LOOP;
         end
         default: begin
            u.act = ACT_FINISH;
         end
      endcase
      return u;
   endfunction

endpackage

// File: hdl/bqlp_seq.sv
module bqlp_seq import bqlp_pkg::*; #(
   parameter int NUM_Y_CHUNKS  = 1,
   parameter int NUM_IN_CHUNKS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        start_preload,
   input  logic        out_free,
   output logic        busy,
   output dp_ctrl_type ctrl
);

   localparam int CNT_W = (NUM_IN_CHUNKS > 1) ? $clog2(NUM_IN_CHUNKS) : 1;
   localparam logic [CNT_W-1:0] Y_LAST  = CNT_W'(NUM_Y_CHUNKS - 1);
   localparam logic [CNT_W-1:0] IN_LAST = CNT_W'(NUM_IN_CHUNKS - 1);

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   uop_type          uop;
   logic             more;

   assign uop  = ucode_rom(pc_ff);
   assign more = (cnt_ff != '0);
   assign busy = busy_ff;

   assign ctrl.mul_en   = busy_ff && ((uop.mul == MUL_ALWAYS) ||
                                      ((uop.mul == MUL_IF_MORE) && more));
   assign ctrl.coef_sel = uop.coef_sel;
   assign ctrl.acc_en   = busy_ff && uop.acc_en;
   assign ctrl.act      = busy_ff ? uop.act : ACT_NONE;

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = start_preload ? STEP_FINISH : STEP_FIRST;
            cnt_in  = Y_LAST;
         end
      end else begin
         priority if (uop.act == ACT_FINISH) begin
            // hold here until the output register can take the result
            if (out_free) begin
               busy_in = 1'b0;
            end
         end else if ((uop.jump == JMP_LOOP) && more) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end else begin
            pc_in = pc_ff + PC_W'(1);
            if (uop.act == ACT_LOAD_Y1) begin
               cnt_in = Y_LAST;
            end else if (uop.act == ACT_LOAD_IN) begin
               cnt_in = IN_LAST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_FIRST;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: hdl/second_order_lowpass_iir_top.sv
// Second-order low-pass biquad on a stream of signed fixed-point samples.
// Request channel (req_valid/req_ready) carries req_cmd and req_sample:
// filter the sample, or preload every history with it and echo it back.
// Response channel (rsp_valid/rsp_ready) carries rsp_filtered, one result
// per request transaction, in order.
// CSR port: csr_we writes csr_wdata to register csr_index (0 gain,
// 1 two-back feedback, 2 one-back feedback); other indexes are ignored.
// Write registers only while no transaction is in flight.
// Sequencing: a filter transaction runs the whole step program, which multiplies
// y2, y1 and the inner sum chunk by chunk (NY, NY and NI chunks, the 32-bit
// chunk counts of a sample and of the inner sum: 1 and 2 at the default widths);
// a preload runs only the last step. A new request is taken the cycle after the
// step program ends, so requests never overlap. The rate is set by the single
// shared 33x33 multiplier: one operand chunk per cycle in its multiply steps.
// A finished result sits in the output register; the next request is taken
// while it waits, but the step program stalls at its last step until the
// receiver frees that register.
// Reset restores unity gain coefficients and clears all histories.
module second_order_lowpass_iir_top import bqlp_pkg::*; #(
   parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   input  logic                           csr_we,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]               csr_wdata
);

   localparam int S        = SAMPLE_WIDTH;
   localparam int F        = COEFF_FRAC_BITS;
   localparam int NY       = (S + CHUNK_W - 1) / CHUNK_W;
   localparam int IW_BASE  = (S + 2 > COEF_W + S - F) ? S + 2 : COEF_W + S - F;
   localparam int IW       = IW_BASE + 2;
   localparam int NI       = (IW + CHUNK_W - 1) / CHUNK_W;
   localparam int OPW      = NI * CHUNK_W;
   localparam int Y_ALIGN  = OPW - NY * CHUNK_W;
   localparam int ACCW     = MUL_A_W + OPW;

   localparam logic signed [S-1:0] SAT_MAX = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0] SAT_MIN = {1'b1, {(S-1){1'b0}}};

   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic signed [COEF_W-1:0] fb2_ff, fb2_in, fb1_ff, fb1_in;
   logic signed [S-1:0]      x1_ff, x1_in, x2_ff, x2_in, y1_ff, y1_in, y2_ff, y2_in;
   logic signed [S-1:0]      x0_ff, x0_in;
   logic                     preload_ff, preload_in;
   logic signed [IW-1:0]     inner_ff, inner_in;
   logic [OPW-1:0]           opnd_ff, opnd_in;
   logic                     first_ff, first_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACCW-1:0]   acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0]      rsp_data_ff, rsp_data_in;

   logic                      busy, req_fire, out_free, finish_fire;
   dp_ctrl_type               ctrl;
   logic signed [IW-1:0]      sum_w, inner_sub;
   logic signed [MUL_A_W-1:0] coef_a;
   logic [CHUNK_W-1:0]        chunk;
   logic signed [MUL_B_W-1:0] opnd_b;
   logic signed [PROD_W-1:0]  mul_res;
   logic signed [ACCW-1:0]    acc_shift, acc_mac;
   logic signed [S-1:0]       res_low, res_sat;
   logic                      res_fits;

   assign req_ready    = !busy;
   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign finish_fire  = (ctrl.act == ACT_FINISH) && out_free;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;

   bqlp_seq #(
      .NUM_Y_CHUNKS  (NY),
      .NUM_IN_CHUNKS (NI)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (req_fire),
      .start_preload (req_cmd == CMD_PRELOAD),
      .out_free      (out_free),
      .busy          (busy),
      .ctrl          (ctrl)
   );

   // x0 + 2*x1 + x2, exact in IW bits
   assign sum_w = IW'(req_sample) + (IW'(x1_ff) <<< 1) + IW'(x2_ff);

   always_comb begin
      unique case (ctrl.coef_sel)
         COEF_FB_TWO: coef_a = MUL_A_W'(fb2_ff);
         COEF_FB_ONE: coef_a = MUL_A_W'(fb1_ff);
         COEF_GAIN:   coef_a = MUL_A_W'(gain_ff);
         default:     coef_a = '0;
      endcase
   end

   // chunks go most significant first; only the top one carries the sign
   assign chunk   = opnd_ff[OPW-1 -: CHUNK_W];
   assign opnd_b  = first_ff ? {chunk[CHUNK_W-1], chunk} : {1'b0, chunk};
   assign mul_res = coef_a * opnd_b;

   assign acc_mac   = (acc_ff <<< CHUNK_W) + ACCW'(prod_ff);
   assign acc_shift = acc_ff >>> F;
   assign inner_sub = inner_ff - IW'(acc_shift);

   assign res_low  = acc_shift[S-1:0];
   assign res_fits = (acc_shift == ACCW'(res_low));
   assign res_sat  = res_fits ? res_low : (acc_shift[ACCW-1] ? SAT_MIN : SAT_MAX);

   always_comb begin
      gain_in      = gain_ff;
      fb2_in       = fb2_ff;
      fb1_in       = fb1_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      x0_in        = x0_ff;
      preload_in   = preload_ff;
      inner_in     = inner_ff;
      opnd_in      = opnd_ff;
      first_in     = first_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:   gain_in = csr_wdata[GAIN_W-1:0];
            CSR_FB_TWO: fb2_in  = csr_wdata[COEF_W-1:0];
            CSR_FB_ONE: fb1_in  = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         x0_in      = req_sample;
         preload_in = (req_cmd == CMD_PRELOAD);
         inner_in   = sum_w;
         opnd_in    = OPW'(y2_ff) <<< Y_ALIGN;
         first_in   = 1'b1;
         acc_in     = '0;
      end

      if (ctrl.mul_en) begin
         prod_in  = mul_res;
         opnd_in  = opnd_ff << CHUNK_W;
         first_in = 1'b0;
      end

      if (ctrl.acc_en) begin
         acc_in = acc_mac;
      end

      if (ctrl.act == ACT_LOAD_Y1) begin
         inner_in = inner_sub;
         opnd_in  = OPW'(y1_ff) <<< Y_ALIGN;
         first_in = 1'b1;
         acc_in   = '0;
      end else if (ctrl.act == ACT_LOAD_IN) begin
         inner_in = inner_sub;
         opnd_in  = OPW'(inner_sub);
         first_in = 1'b1;
         acc_in   = '0;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
         if (preload_ff) begin
            rsp_data_in = x0_ff;
            x1_in       = x0_ff;
            x2_in       = x0_ff;
            y1_in       = x0_ff;
            y2_in       = x0_ff;
         end else begin
            rsp_data_in = res_sat;
            x2_in       = x1_ff;
            x1_in       = x0_ff;
            y2_in       = y1_ff;
            y1_in       = res_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_W'(1) << F;
         fb2_ff       <= COEF_W'(1) << F;
         fb1_ff       <= COEF_W'(2) << F;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         fb2_ff       <= fb2_in;
         fb1_ff       <= fb1_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      preload_ff  <= preload_in;
      inner_ff    <= inner_in;
      opnd_ff     <= opnd_in;
      first_ff    <= first_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: tb/second_order_lowpass_iir_top_test.sv
module second_order_lowpass_iir_top_test;
   import bqlp_pkg::*;

   localparam int SW   = SAMPLE_WIDTH_DEF;
   localparam int FRAC = COEFF_FRAC_BITS_DEF;
   localparam int ONE_Q = 1 << FRAC;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int NUM_DIRECTED    = 35;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int STALL_LIMIT     = 5000;
   localparam int TAIL_CYCLES     = 24;

   typedef enum bit {ROW_ITEM, ROW_REG} row_kind_type;

   typedef enum int {
      STYLE_BUTTERWORTH,
      STYLE_RANDOM,
      STYLE_EXTREME,
      STYLE_RESET
   } coeff_style_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_W-1:0]     wdata;
      logic                 cmd;
      logic [SW-1:0]        sample;
      bit                   known;
      logic [SW-1:0]        want;
   } plan_row_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd   = CMD_FILTER;
   logic signed [SW-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_filtered;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAIN;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // filter state and coefficients as the block should hold them
   logic [GAIN_W-1:0]    gain_q;
   logic signed [COEF_W-1:0] fb_two_q;
   logic signed [COEF_W-1:0] fb_one_q;
   logic signed [SW-1:0] in_one, in_two, out_one, out_two;

   logic signed [SW-1:0] filtered_due [$];
   int                   mismatches  = 0;
   int                   idle_cycles = 0;
   bit                   steady      = 1'b0;

   // identity filter at reset coefficients, so most rows there are known outright
   plan_row_type directed_plan [NUM_DIRECTED] = '{
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h0001_2345, 1'b1, 32'h0001_2345},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h0000_0000, 1'b1, 32'h0000_0000},
      // gain just under two, upper data bits dropped
      '{ROW_REG,  CSR_GAIN,   32'hFFFF_FFFF, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_REG,  CSR_UNUSED, 32'h1234_5678, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h4000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b0, 32'h0},
      '{ROW_REG,  CSR_GAIN,   32'h0,         CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b1, 32'h0000_0000},
      // pure fir: four times a full-scale history saturates
      '{ROW_REG,  CSR_GAIN,   32'h0010_0000, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_REG,  CSR_FB_TWO, 32'h0,         CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_REG,  CSR_FB_ONE, 32'h0,         CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b1, 32'h8000_0000},
      // feedback extremes, wide intermediates
      '{ROW_REG,  CSR_FB_TWO, 32'h8000_0000, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_REG,  CSR_FB_ONE, 32'h7FFF_FFFF, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h8000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h0000_0001, 1'b0, 32'h0},
      '{ROW_REG,  CSR_FB_TWO, 32'h7FFF_FFFF, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_REG,  CSR_FB_ONE, 32'h8000_0000, CMD_FILTER,  32'h0,         1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_PRELOAD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_GAIN,   32'h0,         CMD_FILTER,  32'h0000_0000, 1'b0, 32'h0}
   };

   second_order_lowpass_iir_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic signed [SW-1:0] lowpass_predict(input logic cmd,
                                                           input logic signed [SW-1:0] x0);
      logic signed [127:0] acc, wa, wb, wg, scaled, sat_hi, sat_lo;
      logic signed [SW-1:0] y;
      if (cmd == CMD_PRELOAD) begin
         in_one  = x0;
         in_two  = x0;
         out_one = x0;
         out_two = x0;
         return x0;
      end
      acc = x0;
      wa  = in_one;
      acc = acc + wa + wa;
      wa  = in_two;
      acc = acc + wa;
      wa  = fb_two_q;
      wb  = out_two;
      acc = acc - ((wa * wb) >>> FRAC);
      wa  = fb_one_q;
      wb  = out_one;
      acc = acc - ((wa * wb) >>> FRAC);
      wg  = {{(128 - GAIN_W){1'b0}}, gain_q};
      scaled = (wg * acc) >>> FRAC;
      sat_hi = 128'sh7FFF_FFFF;
      sat_lo = -sat_hi - 1;
      if (scaled > sat_hi)
         y = sat_hi[SW-1:0];
      else if (scaled < sat_lo)
         y = sat_lo[SW-1:0];
      else
         y = scaled[SW-1:0];
      in_two  = in_one;
      in_one  = x0;
      out_two = out_one;
      out_one = y;
      return y;
   endfunction

   task automatic reg_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_GAIN:   gain_q   = data[GAIN_W-1:0];
         CSR_FB_TWO: fb_two_q = data;
         CSR_FB_ONE: fb_one_q = data;
         default:    ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (filtered_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_item(input logic cmd, input logic signed [SW-1:0] sample,
                            input bit known, input logic signed [SW-1:0] want);
      logic signed [SW-1:0] guess;
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      guess = lowpass_predict(cmd, sample);
      filtered_due.push_back(known ? want : guess);
   endtask

   function automatic logic [CSR_W-1:0] coeff_extreme();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'hFFFF_FFFF;
         default: return 32'(ONE_Q);
      endcase
   endfunction

   task automatic program_phase(input coeff_style_type style);
      real c, g, a2, a1;
      logic [CSR_W-1:0] gw, t2, t1;
      case (style)
         STYLE_BUTTERWORTH: begin
            c  = $urandom_range(50, 3000) / 1000.0;
            g  = 1.0 / (1.0 + c * c + 1.414 * c);
            a2 = c * c - 1.414 * c + 1.0;
            a1 = 2.0 - 2.0 * c * c;
            gw = $rtoi(g * ONE_Q);
            t2 = $rtoi(a2 * ONE_Q);
            t1 = $rtoi(a1 * ONE_Q);
         end
         STYLE_RANDOM: begin
            gw = $urandom;
            t2 = $urandom;
            t1 = $urandom;
         end
         STYLE_EXTREME: begin
            gw = coeff_extreme();
            t2 = coeff_extreme();
            t1 = coeff_extreme();
         end
         default: begin
            gw = ONE_Q;
            t2 = ONE_Q;
            t1 = 2 * ONE_Q;
         end
      endcase
      reg_write(CSR_GAIN, gw);
      reg_write(CSR_FB_TWO, t2);
      reg_write(CSR_FB_ONE, t1);
      reg_write(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(0, 99) >= 7);

   always @(posedge clock) begin : check_results
      logic signed [SW-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_due.size() == 0) begin
            $error("filtered: no transaction outstanding, got %0d", rsp_filtered);
            mismatches++;
         end else begin
            want = filtered_due.pop_front();
            if (rsp_filtered !== want) begin
               $error("filtered: expected %0d, got %0d", want, rsp_filtered);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      plan_row_type r;
      bit in_regs;
      int pick;
      logic cmd;
      logic signed [SW-1:0] s;
      in_regs  = 1'b0;
      gain_q   = GAIN_W'(ONE_Q);
      fb_two_q = ONE_Q;
      fb_one_q = 2 * ONE_Q;
      in_one   = '0;
      in_two   = '0;
      out_one  = '0;
      out_two  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         r = directed_plan[i];
         if (r.kind == ROW_REG) begin
            if (!in_regs)
               drain();
            reg_write(r.index, r.wdata);
            in_regs = 1'b1;
         end else begin
            if (in_regs)
               csr_we <= 1'b0;
            in_regs = 1'b0;
            send_item(r.cmd, r.sample, r.known, r.want);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         program_phase(coeff_style_type'(phase % 4));
         // one whole phase with both sides always ready
         steady = (phase == 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            cmd  = ($urandom_range(0, 99) < 10) ? CMD_PRELOAD : CMD_FILTER;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               s = $urandom;
            end else if (pick < 80) begin
               s = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end else if (pick < 90) begin
               case ($urandom_range(0, 3))
                  0:       s = 32'h7FFF_FFFF;
                  1:       s = 32'h8000_0000;
                  2:       s = '0;
                  default: s = '1;
               endcase
            end else begin
               s = int'($urandom_range(0, 16)) - 8;
            end
            send_item(cmd, s, 1'b0, '0);
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (filtered_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
hdl/bqlp_pkg.sv
hdl/bqlp_seq.sv
hdl/second_order_lowpass_iir_top.sv
tb/second_order_lowpass_iir_top_test.sv
